// ===== hw/rtl/rfo_pkg.sv =====
package rfo_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;

    // The chain has DEPTH-1 cells, so the FIFO holds DEPTH-1 words.
    localparam int CELLS = DEPTH - 1;
    localparam int CNT_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
        logic [3:0]  fill_count;
        logic [3:0]  free_space;
    } rsp_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic shift;
        logic write;
        logic clear;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/rfo_cell.sv =====
module rfo_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rfo_pkg::cell_ctl_t                 ctl,
    input  logic                               prev_valid,
    input  logic                               next_valid,
    input  logic [rfo_pkg::WORD_WIDTH-1:0]     next_word,
    input  logic [rfo_pkg::WORD_WIDTH-1:0]     wdata,
    output logic                               valid,
    output logic [rfo_pkg::WORD_WIDTH-1:0]     word
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [rfo_pkg::WORD_WIDTH-1:0] word_reg;
    logic [rfo_pkg::WORD_WIDTH-1:0] word_next;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            // A shift with a write only happens when the chain is full, so the
            // last cell, which has no valid neighbor, takes the new word.
            valid_next = next_valid | ctl.write;
            if (next_valid)
            begin
                word_next = next_word;
            end
            else if (ctl.write)
            begin
                word_next = wdata;
            end
        end
        else if (ctl.write && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            word_next  = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

// ===== hw/rtl/ring_fifo_overwrite_or_decline_core.sv =====
// FIFO of up to 15 words built as a chain of cells, the oldest word in the
// first cell; a read moves every word one cell forward at once.
// Every command (write, read, clear) is taken whenever start is high, so start may be
// high in every cycle and busy is never raised. The result of a command
// appears on result with done high in the cycle after it is taken, for
// exactly one cycle; the receiver cannot stall, so it must capture every
// transfer as it comes. The overwrite mode is written through the cfg port,
// which is always ready, and should only change while no command is pending.
module ring_fifo_overwrite_or_decline_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rfo_pkg::req_t req,
    output logic          done,
    output rfo_pkg::rsp_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    localparam int CELLS = rfo_pkg::CELLS;
    localparam int CNT_W = rfo_pkg::CNT_W;
    localparam int WW    = rfo_pkg::WORD_WIDTH;

    logic                 overwrite_mode_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic                 done_reg;
    rfo_pkg::rsp_t        result_reg;
    rfo_pkg::rsp_t        result_next;
    rfo_pkg::cell_ctl_t   ctl;

    logic [CELLS-1:0]     valid_vec;
    logic [WW-1:0]        word_arr [CELLS];

    logic accept;
    logic is_write;
    logic is_read;
    logic is_clear;
    logic full;
    logic empty;
    logic wr_ok;
    logic rd_ok;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        is_write = 1'b0;
        is_read  = 1'b0;
        is_clear = 1'b0;
        case (req.command)
            rfo_pkg::CMD_WRITE: is_write = 1'b1;
            rfo_pkg::CMD_READ:  is_read  = 1'b1;
            rfo_pkg::CMD_CLEAR: is_clear = 1'b1;
            default:            ;
        endcase
    end

    assign full  = (fill_reg == CNT_W'(CELLS));
    assign empty = (fill_reg == '0);
    assign wr_ok = is_write && (!full || overwrite_mode_reg);
    assign rd_ok = is_read && !empty;

    assign ctl.write = accept && wr_ok;
    assign ctl.shift = accept && (rd_ok || (wr_ok && full));
    assign ctl.clear = accept && is_clear;

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            fill_next = '0;
        end
        else if (accept && rd_ok)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        else if (accept && wr_ok && !full)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        result_next.ok         = wr_ok || rd_ok || is_clear;
        result_next.read_data  = rd_ok ? 32'(word_arr[0]) : '0;
        result_next.fill_count = 4'(fill_next);
        result_next.free_space = 4'(CNT_W'(CELLS) - fill_next);
    end

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        logic          prev_v;
        logic          next_v;
        logic [WW-1:0] next_w;

        if (i == 0)
        begin : g_first
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_v = valid_vec[i-1];
        end

        if (i == CELLS - 1)
        begin : g_last
            assign next_v = 1'b0;
            assign next_w = '0;
        end
        else
        begin : g_inner
            assign next_v = valid_vec[i+1];
            assign next_w = word_arr[i+1];
        end

        rfo_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_word  (next_w),
            .wdata      (req.write_data[WW-1:0]),
            .valid      (valid_vec[i]),
            .word       (word_arr[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overwrite_mode_reg <= 1'b0;
            fill_reg           <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                overwrite_mode_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The occupied cells always form an unbroken run from the head of the chain.
    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + CELLS'(1)) & valid_vec) == '0)
        else $error("cell valid bits are not contiguous from the head");

    // The fill counter matches the number of occupied cells.
    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(fill_reg))
        else $error("fill counter disagrees with occupied cells");

    // Fill count and free space always add up to the capacity.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (5'(result.fill_count) + 5'(result.free_space) == 5'(CELLS)))
        else $error("fill count and free space do not sum to capacity");

    // A failed command never returns data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.read_data == '0))
        else $error("failed command returned nonzero data");

endmodule
